>>> hw/rtl/spq_pkg.sv
// Shared types and constants for the strict-priority three-queue scheduler.
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_COUNT = 256;
	localparam int ENTRY_W = 12;
	localparam int NUM_QUEUES = 3;

	localparam logic [7:0] MAX_RESERVED_RST = 8'd32;
	localparam logic [3:0] HIGHEST_OP_RST = 4'd2;

	typedef enum logic [3:0] {
		OP_ENQUEUE = 4'd0,
		OP_REQUEUE = 4'd1,
		OP_CANCEL = 4'd2,
		OP_TRY_START = 4'd3,
		OP_PICK = 4'd4,
		OP_DRAIN = 4'd5,
		OP_RESERVE = 4'd6,
		OP_RELEASE = 4'd7,
		OP_NOTIFY = 4'd8
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_INVALID = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_RETRY = 3'd3,
		ST_NO_SPACE = 3'd4,
		ST_FULL = 3'd5,
		ST_EMPTY = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CLS_FOREGROUND = 2'd0,
		CLS_PARITY_READ = 2'd1,
		CLS_PARITY_WRITE = 2'd2,
		CLS_NONE = 2'd3
	} qclass_t;

	typedef enum logic {
		CFG_MAX_RESERVED = 1'b0,
		CFG_HIGHEST_OP = 1'b1
	} cfg_idx_t;

endpackage

>>> hw/rtl/spq_cmd_if.sv
// Command channel carrying one scheduler request per beat.
interface spq_cmd_if;
	logic valid;
	logic ready;
	logic [3:0] opcode;
	logic [7:0] request_id;
	logic [1:0] request_class;
	logic [3:0] request_op;

	modport source(output valid, opcode, request_id, request_class, request_op, input ready);
	modport sink(input valid, opcode, request_id, request_class, request_op, output ready);
endinterface

>>> hw/rtl/spq_rsp_if.sv
// Response channel carrying one scheduler result per beat.
interface spq_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [7:0] picked_id;
	logic [1:0] picked_class;
	logic [3:0] picked_op;
	logic [63:0] change_count;
	logic [5:0] pending_count;
	logic [7:0] reserved_count;
	logic [5:0] pending_peak;
	logic [63:0] read_over_write_count;

	modport source(output valid, status, picked_id, picked_class, picked_op, change_count,
		pending_count, reserved_count, pending_peak, read_over_write_count, input ready);
	modport sink(input valid, status, picked_id, picked_class, picked_op, change_count,
		pending_count, reserved_count, pending_peak, read_over_write_count, output ready);
endinterface

>>> hw/rtl/spq_cfg_if.sv
// Configuration write channel: one register write per beat.
interface spq_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [7:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/spq_entry_ram.sv
// Queue entry memory with one write port and one registered read port.
module spq_entry_ram #(
	parameter int AW = 6,
	parameter int DEPTH = 48
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [spq_pkg::ENTRY_W-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [spq_pkg::ENTRY_W-1:0] rdata
);
	import spq_pkg::*;

	logic [ENTRY_W-1:0] mem_q [0:DEPTH-1];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> hw/rtl/strict_priority_three_queue_scheduler_core.sv
// Top level of the strict-priority three-queue request scheduler.
// One command is in flight at a time; the command channel is ready only when the sequencer idles.
// Enqueue scans queued entries one per cycle for a duplicate id.
// Cancel scans and then compacts the queue one entry per cycle.
// Pick and try start read the head of the highest-priority non-empty queue; a result waits if held.
// Reset clears counters, fills and registers to defaults; entry memory is not cleared.
module strict_priority_three_queue_scheduler_core #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	spq_cmd_if.sink cmd,
	spq_rsp_if.source rsp,
	spq_cfg_if.sink cfg
);
	import spq_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(2 * QUEUE_DEPTH + 1);
	localparam int AW = PW + 2;
	localparam int MemDepth = NUM_QUEUES * (2 ** PW);
	localparam logic [FW-1:0] DepthF = FW'(QUEUE_DEPTH);
	localparam logic [1:0] QNone = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_HEAD,
		S_HEADCHK,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t state_q;
	opcode_t opc_q;
	logic [7:0] id_q;
	logic [1:0] cls_q;
	logic [3:0] op_q;
	logic [FW-1:0] fill_q [0:NUM_QUEUES-1];
	logic [NW-1:0] pend_q, peak_q;
	logic [7:0] resv_q, maxr_q;
	logic [3:0] hvo_q;
	logic [63:0] seq_q, row_q;
	logic [1:0] scan_q, tq_q, rq_s1;
	logic [FW-1:0] scan_p_q, sh_q, rp_s1;
	logic rv_s1;
	status_t st_q;
	logic [7:0] pk_id_q;
	logic [1:0] pk_cls_q;
	logic [3:0] pk_op_q;
	logic out_vld_q;
	status_t o_st_q;
	logic [7:0] o_id_q, o_resv_q;
	logic [1:0] o_cls_q;
	logic [3:0] o_op_q;
	logic [63:0] o_seq_q, o_row_q;
	logic [5:0] o_pend_q, o_peak_q;

	logic [ENTRY_W-1:0] rdata, ram_wdata;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic ram_we;
	logic [FW-1:0] cur_fill, tq_fill, enq_fill, wp;
	logic [1:0] top, ecls;
	logic scan_issue, scan_hit, scan_done, sh_issue, is_enq, enq_ok, bad_enq;
	logic [NW-1:0] pend_n;

	always_comb begin
		cur_fill = (scan_q == QNone) ? '0 : fill_q[scan_q];
		tq_fill = (tq_q == QNone) ? '0 : fill_q[tq_q];
		enq_fill = (cls_q == QNone) ? '0 : fill_q[cls_q];
		scan_issue = (scan_q != QNone) && (scan_p_q < cur_fill);
		scan_hit = rv_s1 && (rdata[ENTRY_W-1:4] == id_q);
		scan_done = !rv_s1 && (scan_q == QNone);
		sh_issue = sh_q < tq_fill;
		is_enq = (opc_q == OP_ENQUEUE) || (opc_q == OP_REQUEUE);
		enq_ok = (state_q == S_SCAN) && scan_done && is_enq && (enq_fill < DepthF);
		wp = rp_s1 - FW'(1);
		pend_n = pend_q + NW'(1);
		if (fill_q[0] != '0) begin
			top = 2'd0;
		end else if (fill_q[1] != '0) begin
			top = 2'd1;
		end else if (fill_q[2] != '0) begin
			top = 2'd2;
		end else begin
			top = QNone;
		end
		ecls = (opcode_t'(cmd.opcode) == OP_REQUEUE) ? CLS_PARITY_READ : cmd.request_class;
		bad_enq = (ecls == CLS_NONE) || (cmd.request_op > hvo_q)
			|| (32'(cmd.request_id) >= ID_COUNT);
	end

	always_comb begin
		ram_we = enq_ok || ((state_q == S_SHIFT) && rv_s1);
		if (state_q == S_SHIFT) begin
			ram_waddr = {tq_q, wp[PW-1:0]};
			ram_wdata = rdata;
		end else begin
			ram_waddr = {cls_q, enq_fill[PW-1:0]};
			ram_wdata = {id_q, op_q};
		end
		case (state_q)
			S_SCAN: ram_raddr = {scan_q, scan_p_q[PW-1:0]};
			S_SHIFT: ram_raddr = {tq_q, sh_q[PW-1:0]};
			default: ram_raddr = {tq_q, PW'(0)};
		endcase
	end

	spq_entry_ram #(
		.AW(AW),
		.DEPTH(MemDepth)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			opc_q <= OP_NOTIFY;
			id_q <= '0;
			cls_q <= '0;
			op_q <= '0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				fill_q[i] <= '0;
			end
			pend_q <= '0;
			peak_q <= '0;
			resv_q <= '0;
			maxr_q <= MAX_RESERVED_RST;
			hvo_q <= HIGHEST_OP_RST;
			seq_q <= '0;
			row_q <= '0;
			scan_q <= '0;
			scan_p_q <= '0;
			tq_q <= '0;
			sh_q <= '0;
			rv_s1 <= 1'b0;
			rp_s1 <= '0;
			rq_s1 <= '0;
			st_q <= ST_OK;
			pk_id_q <= '0;
			pk_cls_q <= '0;
			pk_op_q <= '0;
			out_vld_q <= 1'b0;
			o_st_q <= ST_OK;
			o_id_q <= '0;
			o_cls_q <= '0;
			o_op_q <= '0;
			o_seq_q <= '0;
			o_pend_q <= '0;
			o_resv_q <= '0;
			o_peak_q <= '0;
			o_row_q <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg_idx_t'(cfg.index))
					CFG_MAX_RESERVED: maxr_q <= cfg.data;
					CFG_HIGHEST_OP: hvo_q <= cfg.data[3:0];
				endcase
			end
			if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						opc_q <= opcode_t'(cmd.opcode);
						id_q <= cmd.request_id;
						cls_q <= ecls;
						op_q <= cmd.request_op;
						st_q <= ST_OK;
						pk_id_q <= '0;
						pk_cls_q <= '0;
						pk_op_q <= '0;
						rv_s1 <= 1'b0;
						scan_q <= '0;
						scan_p_q <= '0;
						state_q <= S_RESP;
						case (opcode_t'(cmd.opcode))
							OP_ENQUEUE, OP_REQUEUE: begin
								if (bad_enq) begin
									st_q <= ST_INVALID;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_CANCEL: state_q <= S_SCAN;
							OP_TRY_START, OP_PICK: begin
								if (top == QNone) begin
									st_q <= (opcode_t'(cmd.opcode) == OP_PICK) ? ST_EMPTY
										: ST_RETRY;
								end else begin
									tq_q <= top;
									state_q <= S_HEAD;
								end
							end
							OP_DRAIN: begin
								for (int i = 0; i < NUM_QUEUES; i++) begin
									fill_q[i] <= '0;
								end
								pend_q <= '0;
								seq_q <= seq_q + 64'd1;
							end
							OP_RESERVE: begin
								if (resv_q >= maxr_q) begin
									st_q <= ST_NO_SPACE;
								end else begin
									resv_q <= resv_q + 8'd1;
								end
							end
							OP_RELEASE: begin
								if (resv_q != '0) begin
									resv_q <= resv_q - 8'd1;
								end
							end
							OP_NOTIFY: seq_q <= seq_q + 64'd1;
							default: st_q <= ST_INVALID;
						endcase
					end
				end
				S_SCAN: begin
					rv_s1 <= scan_issue;
					rp_s1 <= scan_p_q;
					rq_s1 <= scan_q;
					if (scan_issue) begin
						if (scan_p_q + FW'(1) >= cur_fill) begin
							scan_q <= scan_q + 2'd1;
							scan_p_q <= '0;
						end else begin
							scan_p_q <= scan_p_q + FW'(1);
						end
					end else if (scan_q != QNone) begin
						scan_q <= scan_q + 2'd1;
						scan_p_q <= '0;
					end
					if (scan_hit) begin
						if (is_enq) begin
							st_q <= ST_INVALID;
							state_q <= S_RESP;
						end else begin
							tq_q <= rq_s1;
							sh_q <= rp_s1 + FW'(1);
							rv_s1 <= 1'b0;
							state_q <= S_SHIFT;
						end
					end else if (scan_done) begin
						state_q <= S_RESP;
						if (!is_enq) begin
							st_q <= ST_NOT_FOUND;
						end else if (!enq_ok) begin
							st_q <= ST_FULL;
						end else begin
							fill_q[cls_q] <= enq_fill + FW'(1);
							if (cls_q != CLS_FOREGROUND) begin
								pend_q <= pend_n;
								if (pend_n > peak_q) begin
									peak_q <= pend_n;
								end
							end
							seq_q <= seq_q + 64'd1;
						end
					end
				end
				S_HEAD: state_q <= S_HEADCHK;
				S_HEADCHK: begin
					sh_q <= FW'(1);
					rv_s1 <= 1'b0;
					if (opc_q == OP_PICK) begin
						pk_id_q <= rdata[ENTRY_W-1:4];
						pk_op_q <= rdata[3:0];
						pk_cls_q <= tq_q;
						state_q <= S_SHIFT;
					end else if (rdata[ENTRY_W-1:4] == id_q) begin
						state_q <= S_SHIFT;
					end else begin
						st_q <= ST_RETRY;
						if ((tq_q == CLS_PARITY_READ) && (cls_q == CLS_PARITY_WRITE)) begin
							row_q <= row_q + 64'd1;
						end
						state_q <= S_RESP;
					end
				end
				S_SHIFT: begin
					rv_s1 <= sh_issue;
					rp_s1 <= sh_q;
					if (sh_issue) begin
						sh_q <= sh_q + FW'(1);
					end else if (!rv_s1) begin
						fill_q[tq_q] <= tq_fill - FW'(1);
						if ((tq_q != CLS_FOREGROUND) && (pend_q != '0)) begin
							pend_q <= pend_q - NW'(1);
						end
						seq_q <= seq_q + 64'd1;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q <= 1'b1;
						o_st_q <= st_q;
						o_id_q <= pk_id_q;
						o_cls_q <= pk_cls_q;
						o_op_q <= pk_op_q;
						o_seq_q <= seq_q;
						o_pend_q <= 6'(pend_q);
						o_resv_q <= resv_q;
						o_peak_q <= 6'(peak_q);
						o_row_q <= row_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_vld_q;
	assign rsp.status = o_st_q;
	assign rsp.picked_id = o_id_q;
	assign rsp.picked_class = o_cls_q;
	assign rsp.picked_op = o_op_q;
	assign rsp.change_count = o_seq_q;
	assign rsp.pending_count = o_pend_q;
	assign rsp.reserved_count = o_resv_q;
	assign rsp.pending_peak = o_peak_q;
	assign rsp.read_over_write_count = o_row_q;

	// The parity pending count always equals the parity queue fills.
	a_pend_fill: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == NW'(fill_q[1]) + NW'(fill_q[2]))
		else $error("pending count disagrees with parity queue fills");

	a_peak: assert property (@(posedge clk) disable iff (!arst_n) peak_q >= pend_q)
		else $error("pending peak below pending count");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[0] <= DepthF && fill_q[1] <= DepthF && fill_q[2] <= DepthF)
		else $error("queue fill beyond depth");

	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != $past(seq_q) |-> seq_q == $past(seq_q) + 64'd1)
		else $error("change sequence advanced by more than one");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_RESP))
		else $error("response raised outside the response state");
endmodule

>>> sim/tb_strict_priority_three_queue_scheduler_core.sv
// Testbench for the strict-priority three-queue scheduler: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module tb_strict_priority_three_queue_scheduler_core;
	import spq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [3:0] opcode;
		logic [7:0] request_id;
		logic [1:0] request_class;
		logic [3:0] request_op;
	} command_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] picked_id;
		logic [1:0] picked_class;
		logic [3:0] picked_op;
		logic [63:0] change_count;
		logic [5:0] pending_count;
		logic [7:0] reserved_count;
		logic [5:0] pending_peak;
		logic [63:0] read_over_write_count;
	} outcome_t;

	logic clk;
	logic arst_n;

	spq_cmd_if cmd();
	spq_rsp_if rsp();
	spq_cfg_if cfg();

	strict_priority_three_queue_scheduler_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	// Predictor state.
	logic [7:0] lim_reserved;
	logic [3:0] lim_op;
	logic [7:0] slot_id [3][DEPTH];
	logic [3:0] slot_op [3][DEPTH];
	int fill [3];
	int pend;
	int peak;
	int resv;
	logic [63:0] seq_cnt;
	logic [63:0] row_cnt;

	command_t pending_cmds[$];
	outcome_t expected_outcomes[$];
	int errors;
	int sent_count;
	longint cycles;
	bit hold_long;
	int hold_left;
	bit quiet;

	function automatic bit find_id(input logic [7:0] id, output int qo, output int po);
		for (int q = 0; q < 3; q++)
			for (int p = 0; p < fill[q]; p++)
				if (slot_id[q][p] == id) begin
					qo = q;
					po = p;
					return 1'b1;
				end
		return 1'b0;
	endfunction

	function automatic void take_out(input int q, input int p);
		for (int i = p; i < fill[q] - 1; i++) begin
			slot_id[q][i] = slot_id[q][i + 1];
			slot_op[q][i] = slot_op[q][i + 1];
		end
		fill[q]--;
		if (q != 0 && pend > 0)
			pend--;
	endfunction

	function automatic int head_queue();
		for (int q = 0; q < 3; q++)
			if (fill[q] > 0)
				return q;
		return 3;
	endfunction

	function automatic logic [2:0] put_entry(input logic [7:0] id, input int c,
		input logic [3:0] op);
		int q, p;
		if (c >= 3 || op > lim_op)
			return ST_INVALID;
		if (find_id(id, q, p))
			return ST_INVALID;
		if (fill[c] >= DEPTH)
			return ST_FULL;
		slot_id[c][fill[c]] = id;
		slot_op[c][fill[c]] = op;
		fill[c]++;
		if (c != 0) begin
			pend++;
			if (pend > peak)
				peak = pend;
		end
		seq_cnt++;
		return ST_OK;
	endfunction

	function automatic outcome_t schedule_step(input command_t c);
		outcome_t r;
		int q, p;
		r = '0;
		r.status = ST_OK;
		case (c.opcode)
			OP_ENQUEUE: r.status = put_entry(c.request_id, int'(c.request_class),
				c.request_op);
			OP_REQUEUE: r.status = put_entry(c.request_id, int'(CLS_PARITY_READ),
				c.request_op);
			OP_CANCEL: begin
				if (!find_id(c.request_id, q, p))
					r.status = ST_NOT_FOUND;
				else begin
					take_out(q, p);
					seq_cnt++;
				end
			end
			OP_TRY_START: begin
				q = head_queue();
				if (q < 3 && slot_id[q][0] == c.request_id) begin
					take_out(q, 0);
					seq_cnt++;
				end else begin
					if (q == CLS_PARITY_READ && c.request_class == CLS_PARITY_WRITE)
						row_cnt++;
					r.status = ST_RETRY;
				end
			end
			OP_PICK: begin
				q = head_queue();
				if (q >= 3)
					r.status = ST_EMPTY;
				else begin
					r.picked_id = slot_id[q][0];
					r.picked_op = slot_op[q][0];
					r.picked_class = q[1:0];
					take_out(q, 0);
					seq_cnt++;
				end
			end
			OP_DRAIN: begin
				fill = '{0, 0, 0};
				pend = 0;
				seq_cnt++;
			end
			OP_RESERVE: begin
				if (resv >= lim_reserved)
					r.status = ST_NO_SPACE;
				else
					resv++;
			end
			OP_RELEASE: begin
				if (resv > 0)
					resv--;
			end
			OP_NOTIFY: seq_cnt++;
			default: r.status = ST_INVALID;
		endcase
		r.change_count = seq_cnt;
		r.pending_count = pend[5:0];
		r.reserved_count = resv[7:0];
		r.pending_peak = peak[5:0];
		r.read_over_write_count = row_cnt;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycles <= cycles + 1;

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				expected_outcomes.push_back(schedule_step(pending_cmds.pop_front()));
				sent_count++;
			end
			if ((!cmd.valid || cmd.ready) && pending_cmds.size() > 0 &&
				(quiet || $urandom_range(99) >= 21)) begin
				cmd.valid <= 1'b1;
				cmd.opcode <= pending_cmds[0].opcode;
				cmd.request_id <= pending_cmds[0].request_id;
				cmd.request_class <= pending_cmds[0].request_class;
				cmd.request_op <= pending_cmds[0].request_op;
			end else if (cmd.ready)
				cmd.valid <= 1'b0;
		end
	end

	// Stall counter for the long receiver hold-off.
	always @(posedge clk) begin
		if (hold_long) begin
			hold_long <= 1'b0;
			hold_left <= 300;
		end else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		outcome_t w;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("unexpected result beat", 64'(rsp.status), 64'd0);
				end else begin
					w = expected_outcomes.pop_front();
					if (rsp.status !== w.status)
						report_mismatch("status", 64'(rsp.status), 64'(w.status));
					if (rsp.picked_id !== w.picked_id)
						report_mismatch("picked_id", 64'(rsp.picked_id), 64'(w.picked_id));
					if (rsp.picked_class !== w.picked_class)
						report_mismatch("picked_class", 64'(rsp.picked_class),
							64'(w.picked_class));
					if (rsp.picked_op !== w.picked_op)
						report_mismatch("picked_op", 64'(rsp.picked_op), 64'(w.picked_op));
					if (rsp.change_count !== w.change_count)
						report_mismatch("change_count", rsp.change_count, w.change_count);
					if (rsp.pending_count !== w.pending_count)
						report_mismatch("pending_count", 64'(rsp.pending_count),
							64'(w.pending_count));
					if (rsp.reserved_count !== w.reserved_count)
						report_mismatch("reserved_count", 64'(rsp.reserved_count),
							64'(w.reserved_count));
					if (rsp.pending_peak !== w.pending_peak)
						report_mismatch("pending_peak", 64'(rsp.pending_peak),
							64'(w.pending_peak));
					if (rsp.read_over_write_count !== w.read_over_write_count)
						report_mismatch("read_over_write_count", rsp.read_over_write_count,
							w.read_over_write_count);
				end
			end
			rsp.ready <= (hold_left == 0 && !hold_long) && (quiet || $urandom_range(99) >= 21);
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic add_cmd(input opcode_t o, input logic [7:0] id, input logic [1:0] c,
		input logic [3:0] op);
		command_t x;
		x.opcode = o;
		x.request_id = id;
		x.request_class = c;
		x.request_op = op;
		pending_cmds.push_back(x);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		if (idx == CFG_MAX_RESERVED)
			lim_reserved = v;
		else
			lim_op = v[3:0];
	endtask

	task automatic settle();
		while (pending_cmds.size() > 0 || expected_outcomes.size() > 0 || cmd.valid)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic random_phase(input int n);
		command_t x;
		for (int i = 0; i < n; i++) begin
			x.request_id = $urandom_range(99) < 85 ? 8'($urandom_range(23)) : 8'($urandom);
			x.request_class = $urandom_range(99) < 90 ? 2'($urandom_range(2)) : 2'd3;
			x.request_op = $urandom_range(99) < 80 ? 4'($urandom_range(lim_op)) : 4'($urandom);
			case ($urandom_range(99)) inside
				[0:29]: x.opcode = OP_ENQUEUE;
				[30:37]: x.opcode = OP_REQUEUE;
				[38:47]: x.opcode = OP_CANCEL;
				[48:59]: x.opcode = OP_TRY_START;
				[60:74]: x.opcode = OP_PICK;
				[75:76]: x.opcode = OP_DRAIN;
				[77:84]: x.opcode = OP_RESERVE;
				[85:92]: x.opcode = OP_RELEASE;
				[93:96]: x.opcode = OP_NOTIFY;
				default: x.opcode = 4'($urandom_range(15, 9));
			endcase
			// Try start often names the real head so it can succeed.
			if (x.opcode == OP_TRY_START && $urandom_range(1) == 1 && head_queue() < 3)
				x.request_id = slot_id[head_queue()][0];
			pending_cmds.push_back(x);
		end
	endtask

	initial begin
		errors = 0;
		sent_count = 0;
		cycles = 0;
		hold_long = 1'b0;
		hold_left = 0;
		quiet = 1'b0;
		cmd.valid = 1'b0;
		cmd.opcode = '0;
		cmd.request_id = '0;
		cmd.request_class = '0;
		cmd.request_op = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_MAX_RESERVED;
		cfg.data = '0;
		lim_reserved = MAX_RESERVED_RST;
		lim_op = HIGHEST_OP_RST;
		fill = '{0, 0, 0};
		pend = 0;
		peak = 0;
		resv = 0;
		seq_cnt = '0;
		row_cnt = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_cmd(OP_PICK, 8'd0, CLS_FOREGROUND, 4'd0);
		add_cmd(OP_TRY_START, 8'd5, CLS_PARITY_WRITE, 4'd0);
		add_cmd(OP_CANCEL, 8'd7, CLS_FOREGROUND, 4'd0);
		add_cmd(OP_ENQUEUE, 8'd255, CLS_FOREGROUND, 4'd2);
		add_cmd(OP_ENQUEUE, 8'd255, CLS_PARITY_READ, 4'd1);
		add_cmd(OP_ENQUEUE, 8'd1, CLS_NONE, 4'd0);
		add_cmd(OP_ENQUEUE, 8'd2, CLS_FOREGROUND, 4'd15);
		add_cmd(OP_REQUEUE, 8'd0, CLS_FOREGROUND, 4'd0);
		add_cmd(OP_ENQUEUE, 8'd3, CLS_PARITY_WRITE, 4'd1);
		add_cmd(OP_TRY_START, 8'd3, CLS_PARITY_WRITE, 4'd0);
		add_cmd(OP_PICK, 8'd0, CLS_FOREGROUND, 4'd0);
		add_cmd(OP_TRY_START, 8'd3, CLS_PARITY_WRITE, 4'd0);
		add_cmd(OP_TRY_START, 8'd0, CLS_PARITY_READ, 4'd0);
		add_cmd(OP_CANCEL, 8'd3, CLS_FOREGROUND, 4'd0);
		add_cmd(OP_RELEASE, 8'd0, CLS_FOREGROUND, 4'd0);
		add_cmd(OP_RESERVE, 8'd0, CLS_FOREGROUND, 4'd0);
		add_cmd(OP_NOTIFY, 8'd0, CLS_FOREGROUND, 4'd0);
		add_cmd(OP_DRAIN, 8'd0, CLS_FOREGROUND, 4'd0);
		add_cmd(opcode_t'(4'd15), 8'd0, CLS_FOREGROUND, 4'd0);
		for (int i = 0; i < DEPTH + 1; i++)
			add_cmd(OP_ENQUEUE, 8'(100 + i), CLS_PARITY_WRITE, 4'd0);
		settle();

		write_reg(CFG_MAX_RESERVED, 8'd0);
		write_reg(CFG_HIGHEST_OP, 8'd15);
		add_cmd(OP_RESERVE, 8'd0, CLS_FOREGROUND, 4'd0);
		add_cmd(OP_DRAIN, 8'd0, CLS_FOREGROUND, 4'd0);
		random_phase(150);
		// Fill the block behind a long receiver stall.
		hold_long = 1'b1;
		settle();

		write_reg(CFG_MAX_RESERVED, 8'd255);
		write_reg(CFG_HIGHEST_OP, 8'd0);
		for (int i = 0; i < 300; i++)
			add_cmd(OP_RESERVE, 8'd0, CLS_FOREGROUND, 4'd0);
		settle();

		write_reg(CFG_MAX_RESERVED, 8'd3);
		write_reg(CFG_HIGHEST_OP, 8'd7);
		quiet = 1'b1;
		random_phase(150);
		settle();
		quiet = 1'b0;
		random_phase(250);
		settle();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

>>> strict_priority_three_queue_scheduler_core.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cmd_if.sv
hw/rtl/spq_rsp_if.sv
hw/rtl/spq_cfg_if.sv
hw/rtl/spq_entry_ram.sv
hw/rtl/strict_priority_three_queue_scheduler_core.sv
sim/tb_strict_priority_three_queue_scheduler_core.sv
